// ===== src/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, widths and the bilinear weight function of the sampler.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // Field and datapath widths.
    localparam int FRAC_W   = 4;
    localparam int STYLE_W  = 10;
    localparam int TEXEL_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int WEIGHT_W = 9;
    localparam int DOT_W    = 16;
    localparam int PROD_W   = DOT_W + STYLE_W;
    localparam int SUM_W    = 28;
    localparam int COUNT_W  = 3;
    localparam int TAPS     = 4;
    localparam int CHANNELS = 3;

    // Packed stream widths.
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 88;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef logic [TAPS-1:0][WEIGHT_W-1:0] weight_vec_t;
    typedef logic [TAPS-1:0][CHAN_W-1:0]   chan_vec_t;

    // Control that travels beside the datapath through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    // Weights in 1/256 units: (16-s)(16-t), s(16-t), (16-s)t and s*t.
    function automatic weight_vec_t bilinear_weights(input logic [FRAC_W-1:0] s,
                                                     input logic [FRAC_W-1:0] t);
        logic [FRAC_W:0]     sc;
        logic [FRAC_W:0]     tc;
        logic [FRAC_W:0]     se;
        logic [FRAC_W:0]     te;
        logic [2*FRAC_W+1:0] p0;
        logic [2*FRAC_W+1:0] p1;
        logic [2*FRAC_W+1:0] p2;
        logic [2*FRAC_W+1:0] p3;
        weight_vec_t         w;
        se = {1'b0, s};
        te = {1'b0, t};
        sc = (FRAC_W+1)'(16) - se;
        tc = (FRAC_W+1)'(16) - te;
        p0 = sc * tc;
        p1 = se * tc;
        p2 = sc * te;
        p3 = se * te;
        w[0] = p0[WEIGHT_W-1:0];
        w[1] = p1[WEIGHT_W-1:0];
        w[2] = p2[WEIGHT_W-1:0];
        w[3] = p3[WEIGHT_W-1:0];
        return w;
    endfunction

endpackage

// ===== src/lbs_lane.sv =====
// ----------------------------------------------------------------------------
// lbs_lane
// One colour channel: weighted sum of the four texels, then the style scale.
// ----------------------------------------------------------------------------
module lbs_lane
    import lbs_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  weight_vec_t         weights,
    input  chan_vec_t           texels,
    input  logic [STYLE_W-1:0]  style,
    output logic [PROD_W-1:0]   product
);

    logic [DOT_W+1:0]   dot_sum;
    logic [DOT_W-1:0]   dot_reg;
    logic [DOT_W-1:0]   dot_next;
    logic [STYLE_W-1:0] style_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;

    // Four small products summed; the weights add to 256, so 16 bits suffice.
    always_comb
    begin
        dot_sum = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            dot_sum = dot_sum + ((DOT_W+2)'(weights[i]) * (DOT_W+2)'(texels[i]));
        end
        dot_next = dot_sum[DOT_W-1:0];
    end

    // Second stage scales the filtered texel by the light style.
    assign prod_next = PROD_W'(dot_reg) * PROD_W'(style_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg   <= dot_next;
            style_reg <= style;
            prod_reg  <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

// ===== src/lbs_merge.sv =====
// ----------------------------------------------------------------------------
// lbs_merge
// Accumulates the lane results over the layers of a group and holds the
// finished result for the output stream.
// ----------------------------------------------------------------------------
module lbs_merge
    import lbs_pkg::*;
#(
    parameter int MAX_MAPS = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  stage_ctrl_t                         ctrl,
    input  logic [CHANNELS-1:0][PROD_W-1:0]     products,
    output logic                                advance,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_DATA_W-1:0]               m_tdata   // red, green, blue, maps_used
);

    logic [CHANNELS-1:0][SUM_W-1:0] sum_reg;
    logic [CHANNELS-1:0][SUM_W-1:0] sum_next;
    logic [CHANNELS-1:0][SUM_W-1:0] sat_sum;
    logic [COUNT_W-1:0]             count_reg;
    logic [COUNT_W-1:0]             count_next;
    logic [COUNT_W-1:0]             count_inc;
    logic [CHANNELS-1:0][SUM_W-1:0] res_reg;
    logic [CHANNELS-1:0][SUM_W-1:0] res_next;
    logic [COUNT_W-1:0]             maps_reg;
    logic [COUNT_W-1:0]             maps_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           emit;
    logic                           take;

    // Saturating add of each lane into its running sum.
    always_comb
    begin
        logic [SUM_W:0] wide;
        for (int c = 0; c < CHANNELS; c++)
        begin
            wide       = {1'b0, sum_reg[c]} + (SUM_W+1)'(products[c]);
            sat_sum[c] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
        end
    end

    // A group closes on the last layer or when the layer limit is reached.
    assign count_inc = count_reg + COUNT_W'(1);
    assign emit      = ctrl.last || (count_inc >= COUNT_W'(MAX_MAPS));
    assign advance   = !(ctrl.valid && emit && out_valid_reg && !m_tready);
    assign take      = advance && ctrl.valid;

    // Next state for the sums, the layer count and the output register.
    always_comb
    begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        maps_next      = maps_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (take)
        begin
            if (emit)
            begin
                res_next       = sat_sum;
                maps_next      = count_inc;
                sum_next       = '0;
                count_next     = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                sum_next   = sat_sum;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        maps_reg <= maps_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, maps_reg, res_reg[2], res_reg[1], res_reg[0]};

    // The layer count of an open group stays below the limit.
    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_W'(MAX_MAPS))
        else $error("layer count reached the limit without closing the group");

    // A result held on the output covers between one and MAX_MAPS layers.
    a_maps_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (maps_reg != '0) && (maps_reg <= COUNT_W'(MAX_MAPS)))
        else $error("maps_used out of range");

    // Closing a group clears the accumulator.
    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> (count_reg == '0) && (sum_reg == '0))
        else $error("accumulator not cleared after a group closed");

    // The pipeline only stalls while a finished result is still waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> (out_valid_reg && !m_tready))
        else $error("pipeline stalled without a waiting result");

endmodule

// ===== src/lightmap_bilinear_sampler.sv =====
// A group's result passes through the weights, lane filter, style scale and
// accumulate registers after its last layer request is accepted, then appears on m_tvalid.
// Throughput: one layer per cycle; the pipeline holds only while a finished
// result waits for m_tready and another group is about to close.
// Reset: rst_n clears the sums, the layer count and all valid flags at once.
// ----------------------------------------------------------------------------
// lightmap_bilinear_sampler
// Bilinear lightmap sampler with three channel lanes and a merging
// accumulator that sums the lit value over the layers of a surface sample.
// ----------------------------------------------------------------------------
module lightmap_bilinear_sampler
    import lbs_pkg::*;
#(
    parameter int MAX_MAPS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_frac, t_frac, style_value, texel_00, texel_01, texel_10, texel_11
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,   // last_map
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // red, green, blue, maps_used
);

    logic                           en;
    logic [FRAC_W-1:0]              s_frac;
    logic [FRAC_W-1:0]              t_frac;
    logic [STYLE_W-1:0]             style_value;
    logic [TAPS-1:0][TEXEL_W-1:0]   texel_in;
    weight_vec_t                    weight_reg;
    logic [TAPS-1:0][TEXEL_W-1:0]   texel_reg;
    logic [STYLE_W-1:0]             style_reg;
    stage_ctrl_t                    ctrl_a_reg;
    stage_ctrl_t                    ctrl_b_reg;
    stage_ctrl_t                    ctrl_c_reg;
    stage_ctrl_t                    ctrl_a_next;
    logic [CHANNELS-1:0][PROD_W-1:0] products;

    // Unpack the request payload.
    assign s_frac      = s_tdata[3:0];
    assign t_frac      = s_tdata[7:4];
    assign style_value = s_tdata[17:8];
    assign texel_in[0] = s_tdata[41:18];
    assign texel_in[1] = s_tdata[65:42];
    assign texel_in[2] = s_tdata[89:66];
    assign texel_in[3] = s_tdata[113:90];

    assign s_tready          = en;
    assign ctrl_a_next.valid = s_tvalid;
    assign ctrl_a_next.last  = s_tlast;

    // Control flags advance with the datapath on every enabled cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
        end
        else if (en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_a_reg;
            ctrl_c_reg <= ctrl_b_reg;
        end
    end

    // Input stage: register the texels and compute the bilinear weights.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= bilinear_weights(s_frac, t_frac);
            texel_reg  <= texel_in;
            style_reg  <= style_value;
        end
    end

    // One lane per colour channel.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        chan_vec_t lane_texels;

        for (genvar i = 0; i < TAPS; i++)
        begin : g_tap
            assign lane_texels[i] = texel_reg[i][c*CHAN_W +: CHAN_W];
        end

        lbs_lane u_lane (
            .clk     (clk),
            .en      (en),
            .weights (weight_reg),
            .texels  (lane_texels),
            .style   (style_reg),
            .product (products[c])
        );
    end

    // Merge the lanes into the per-group sums.
    lbs_merge #(
        .MAX_MAPS (MAX_MAPS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_c_reg),
        .products (products),
        .advance  (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
